// File: sv/dltc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dltc_pkg;

	// Field widths fixed by the level and result formats.
	localparam int unsigned RATE_W    = 24;
	localparam int unsigned VOLT_W    = 22;
	localparam int unsigned DIV_W     = 16;
	localparam int unsigned CCOUNT_W  = 4;
	localparam int unsigned LVL_W     = 6;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned DIV_PORTS = 7;

	// Defaults of the top-level parameters.
	localparam int unsigned MAX_CLOCKS_DEF  = 8;
	localparam int unsigned LEVEL_LIMIT_DEF = 32;

	// Limits of the level checks and start values of the table state.
	localparam logic [DIV_W-1:0]  DIVIDER_MAX   = 16'd63;
	localparam logic [VOLT_W-1:0] VOLTAGE_FLOOR = 22'd500000;
	localparam logic [RATE_W-1:0] RATE_ALL_ONES = '1;
	localparam logic [VOLT_W-1:0] VOLT_ALL_ONES = '1;

	// Register reset values.
	localparam logic [RATE_W-1:0]   MIN_RATE_RST  = '0;
	localparam logic [RATE_W-1:0]   MAX_RATE_RST  = '1;
	localparam logic [VOLT_W-1:0]   MAX_VOLT_RST  = 22'd1475000;
	localparam logic [CCOUNT_W-1:0] CCOUNT_RST    = 4'd1;
	localparam logic [LVL_W-1:0]    LEVEL_SEL_RST = '1;

	// Register word indexes on the configuration port.
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_RATE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RATE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_VOLT  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CCOUNT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BOOT_LVL  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RESUME_LVL = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [RATE_W-1:0]   rate_lo;
		logic [RATE_W-1:0]   rate_hi;
		logic [VOLT_W-1:0]   max_volt;
		logic [CCOUNT_W-1:0] clock_count;
		logic [LVL_W-1:0]    boot_idx;
		logic [LVL_W-1:0]    resume_idx;
	} dltc_cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                table_done;
		logic [RATE_W-1:0]   top_khz;
		logic [RATE_W-1:0]   bottom_khz;
		logic [LVL_W-1:0]    levels_seen;
	} dltc_result_t;

endpackage

`default_nettype wire

// File: sv/dltc_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module dltc_lane #(
	parameter int unsigned LANE = 1
) (
	input  wire logic [dltc_pkg::CCOUNT_W-1:0] clock_count,
	input  wire logic [dltc_pkg::DIV_W-1:0]    divider,
	output logic                               bad
);
	import dltc_pkg::*;

	logic in_use;

	// A clock value counts only if the configured count reaches past this lane.
	assign in_use = clock_count > CCOUNT_W'(LANE);
	assign bad    = in_use && (divider > DIVIDER_MAX);

endmodule

`default_nettype wire

// File: sv/dltc_level_check.sv
`timescale 1ns / 1ps
`default_nettype none

module dltc_level_check #(
	parameter int unsigned MAX_CLOCKS  = dltc_pkg::MAX_CLOCKS_DEF,
	parameter int unsigned LEVEL_LIMIT = dltc_pkg::LEVEL_LIMIT_DEF
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           accept,
	input  wire dltc_pkg::dltc_cfg_t                            cfg,
	input  wire logic [dltc_pkg::RATE_W-1:0]                    level_rate,
	input  wire logic [dltc_pkg::VOLT_W-1:0]                    level_volt,
	input  wire logic                                           level_enabled,
	input  wire logic [dltc_pkg::RATE_W-1:0]                    first_clock,
	input  wire logic [dltc_pkg::DIV_PORTS-1:0][dltc_pkg::DIV_W-1:0] dividers,
	input  wire logic                                           is_last,
	output dltc_pkg::dltc_result_t                              result
);
	import dltc_pkg::*;

	// Table state.
	logic [RATE_W-1:0]   prior_rate_q, prior_rate_n;
	logic [VOLT_W-1:0]   prior_volt_q, prior_volt_n;
	logic [RATE_W-1:0]   top_q, top_n;
	logic [RATE_W-1:0]   bottom_q, bottom_n;
	logic [LVL_W-1:0]    tally_q, tally_n;
	logic [LVL_W-1:0]    index_q, index_n;
	logic [STATUS_W-1:0] first_err_q, first_err_n;
	logic                boot_en_q, boot_en_n;
	logic                resume_en_q, resume_en_n;

	logic [MAX_CLOCKS-1:0] lane_bad;
	logic                  div_err;
	logic                  over_limit;
	logic                  order_bad;
	logic                  volt_bad;
	logic [STATUS_W-1:0]   level_err;
	logic                  commit;
	logic [STATUS_W-1:0]   final_status;

	// Bad index: below minus one, past the level count, or naming a disabled level.
	function automatic logic index_bad(input logic [LVL_W-1:0] idx,
			input logic [LVL_W-1:0] count, input logic enabled);
		logic result_bad;
		if (idx[LVL_W-1]) begin
			result_bad = (idx != LEVEL_SEL_RST);
		end else begin
			result_bad = (idx >= count) || !enabled;
		end
		return result_bad;
	endfunction

	// One lane per divider that can be in use; the first clock has no lane.
	assign lane_bad[0] = 1'b0;
	for (genvar j = 1; j < MAX_CLOCKS; j++) begin : g_lane
		dltc_lane #(
			.LANE(j)
		) u_lane (
			.clock_count(cfg.clock_count),
			.divider    (dividers[j-1]),
			.bad        (lane_bad[j])
		);
	end

	// Merge the lane results with the rate and voltage tests.
	always_comb begin
		div_err    = |lane_bad;
		over_limit = index_q >= LVL_W'(LEVEL_LIMIT);
		order_bad  = ((index_q != '0) && (level_rate >= prior_rate_q)) ||
			(level_rate < cfg.rate_lo) || (level_rate > cfg.rate_hi) ||
			(first_clock != level_rate);
		volt_bad   = level_enabled && ((level_volt < VOLTAGE_FLOOR) ||
			(level_volt > cfg.max_volt) || (level_volt > prior_volt_q));
		priority if (over_limit || order_bad) begin
			level_err = ST_ORDER;
		end else if (div_err || volt_bad) begin
			level_err = ST_RANGE;
		end else begin
			level_err = ST_OK;
		end
		commit = (level_err == ST_OK) && (first_err_q == ST_OK);
	end

	// Next table state after this level.
	always_comb begin
		prior_rate_n = prior_rate_q;
		prior_volt_n = prior_volt_q;
		top_n        = top_q;
		bottom_n     = bottom_q;
		tally_n      = tally_q;
		boot_en_n    = boot_en_q;
		resume_en_n  = resume_en_q;
		if (commit) begin
			prior_rate_n = level_rate;
			if (level_enabled) begin
				prior_volt_n = level_volt;
				if (tally_q == '0) begin
					top_n = level_rate;
				end
				bottom_n = level_rate;
				tally_n  = tally_q + 1'b1;
				if (!cfg.boot_idx[LVL_W-1] && (cfg.boot_idx == index_q)) begin
					boot_en_n = 1'b1;
				end
				if (!cfg.resume_idx[LVL_W-1] && (cfg.resume_idx == index_q)) begin
					resume_en_n = 1'b1;
				end
			end
		end
		index_n     = over_limit ? index_q : index_q + 1'b1;
		first_err_n = (first_err_q == ST_OK) ? level_err : first_err_q;
	end

	// Closing status of the table.
	always_comb begin
		priority if (first_err_n != ST_OK) begin
			final_status = first_err_n;
		end else if (tally_n == '0) begin
			final_status = ST_EMPTY;
		end else if (index_bad(cfg.boot_idx, index_n, boot_en_n) ||
				index_bad(cfg.resume_idx, index_n, resume_en_n)) begin
			final_status = ST_ORDER;
		end else begin
			final_status = ST_OK;
		end
	end

	// Result of this level.
	always_comb begin
		result.table_done  = is_last;
		result.levels_seen = index_n;
		result.status      = is_last ? final_status : first_err_n;
		result.top_khz     = '0;
		result.bottom_khz  = '0;
		if (is_last && (final_status == ST_OK)) begin
			result.top_khz    = top_n;
			result.bottom_khz = bottom_n;
		end
	end

	// The last level returns the table state to its start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_rate_q <= RATE_ALL_ONES;
			prior_volt_q <= VOLT_ALL_ONES;
			top_q        <= '0;
			bottom_q     <= '0;
			tally_q      <= '0;
			index_q      <= '0;
			first_err_q  <= ST_OK;
			boot_en_q    <= 1'b0;
			resume_en_q  <= 1'b0;
		end else if (accept) begin
			if (is_last) begin
				prior_rate_q <= RATE_ALL_ONES;
				prior_volt_q <= VOLT_ALL_ONES;
				top_q        <= '0;
				bottom_q     <= '0;
				tally_q      <= '0;
				index_q      <= '0;
				first_err_q  <= ST_OK;
				boot_en_q    <= 1'b0;
				resume_en_q  <= 1'b0;
			end else begin
				prior_rate_q <= prior_rate_n;
				prior_volt_q <= prior_volt_n;
				top_q        <= top_n;
				bottom_q     <= bottom_n;
				tally_q      <= tally_n;
				index_q      <= index_n;
				first_err_q  <= first_err_n;
				boot_en_q    <= boot_en_n;
				resume_en_q  <= resume_en_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/dltc_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module dltc_out_buf (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire dltc_pkg::dltc_result_t push_data,
	output logic                        full,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output dltc_pkg::dltc_result_t      out_data
);
	import dltc_pkg::*;

	logic         main_valid_q;
	logic         skid_valid_q;
	dltc_result_t main_q;
	dltc_result_t skid_q;
	logic         take;
	logic         load_main;
	logic         load_skid;

	// The skid entry catches a transfer that arrives while the output is held.
	assign take      = main_valid_q && !out_stall;
	assign load_main = skid_valid_q ? take : (push && (!main_valid_q || take));
	assign load_skid = push && !skid_valid_q && main_valid_q && !take;

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Occupancy flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (load_skid) begin
				skid_valid_q <= 1'b1;
			end else if (!push && take) begin
				main_valid_q <= 1'b0;
			end else if (load_main) begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_main) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end
		if (load_skid) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/dvfs_level_table_checker.sv
// Each level's result is registered in the output stage when the level transfers.
// One level per cycle while the output stage is not full; the table state updates in the same cycle as the checks.
// A two-entry output stage keeps input transfers going for one more level during an output stall.
// Reset clears the table state and the output stage and loads the register defaults.
// Configuration registers keep their values across tables.
`timescale 1ns / 1ps
`default_nettype none

module dvfs_level_table_checker #(
	parameter int unsigned MAX_CLOCKS  = dltc_pkg::MAX_CLOCKS_DEF,
	parameter int unsigned LEVEL_LIMIT = dltc_pkg::LEVEL_LIMIT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration port.
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [4:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	// Level channel.
	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic [dltc_pkg::RATE_W-1:0]       level_rate,
	input  wire logic [dltc_pkg::VOLT_W-1:0]       level_volt,
	input  wire logic                              level_enabled,
	input  wire logic [dltc_pkg::RATE_W-1:0]       first_clock,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_1,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_2,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_3,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_4,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_5,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_6,
	input  wire logic [dltc_pkg::DIV_W-1:0]        divider_7,
	input  wire logic                              is_last,
	// Result channel.
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic [dltc_pkg::STATUS_W-1:0]          status,
	output logic                                   table_done,
	output logic [dltc_pkg::RATE_W-1:0]            top_enabled_khz,
	output logic [dltc_pkg::RATE_W-1:0]            bottom_enabled_khz,
	output logic [dltc_pkg::LVL_W-1:0]             levels_seen
);
	import dltc_pkg::*;

	dltc_cfg_t                         cfg_q;
	logic                              cfg_write;
	logic [REG_IDX_W-1:0]              reg_idx;
	logic                              accept;
	logic [DIV_PORTS-1:0][DIV_W-1:0]   dividers;
	dltc_result_t                      level_result;
	dltc_result_t                      out_result;
	logic                              buf_full;

	// Register file on the configuration port.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[4:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_lo     <= MIN_RATE_RST;
			cfg_q.rate_hi     <= MAX_RATE_RST;
			cfg_q.max_volt    <= MAX_VOLT_RST;
			cfg_q.clock_count <= CCOUNT_RST;
			cfg_q.boot_idx    <= LEVEL_SEL_RST;
			cfg_q.resume_idx  <= LEVEL_SEL_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_MIN_RATE:   cfg_q.rate_lo     <= pwdata[RATE_W-1:0];
				REG_MAX_RATE:   cfg_q.rate_hi     <= pwdata[RATE_W-1:0];
				REG_MAX_VOLT:   cfg_q.max_volt    <= pwdata[VOLT_W-1:0];
				REG_CCOUNT:     cfg_q.clock_count <= pwdata[CCOUNT_W-1:0];
				REG_BOOT_LVL:   cfg_q.boot_idx    <= pwdata[LVL_W-1:0];
				REG_RESUME_LVL: cfg_q.resume_idx  <= pwdata[LVL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back; the level indexes are sign-extended.
	always_comb begin
		unique case (reg_idx)
			REG_MIN_RATE:   prdata = 32'(cfg_q.rate_lo);
			REG_MAX_RATE:   prdata = 32'(cfg_q.rate_hi);
			REG_MAX_VOLT:   prdata = 32'(cfg_q.max_volt);
			REG_CCOUNT:     prdata = 32'(cfg_q.clock_count);
			REG_BOOT_LVL:   prdata = 32'(signed'(cfg_q.boot_idx));
			REG_RESUME_LVL: prdata = 32'(signed'(cfg_q.resume_idx));
			default:        prdata = '0;
		endcase
	end

	// Level transfer.
	assign item_stall = buf_full;
	assign accept     = item_valid && !item_stall;
	assign dividers   = {divider_7, divider_6, divider_5, divider_4,
		divider_3, divider_2, divider_1};

	dltc_level_check #(
		.MAX_CLOCKS (MAX_CLOCKS),
		.LEVEL_LIMIT(LEVEL_LIMIT)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cfg          (cfg_q),
		.level_rate   (level_rate),
		.level_volt   (level_volt),
		.level_enabled(level_enabled),
		.first_clock  (first_clock),
		.dividers     (dividers),
		.is_last      (is_last),
		.result       (level_result)
	);

	dltc_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(level_result),
		.full     (buf_full),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data (out_result)
	);

	assign status             = out_result.status;
	assign table_done         = out_result.table_done;
	assign top_enabled_khz    = out_result.top_khz;
	assign bottom_enabled_khz = out_result.bottom_khz;
	assign levels_seen        = out_result.levels_seen;

endmodule

`default_nettype wire

// File: sv/dltc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dltc_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              result_valid,
	input wire logic                              result_stall,
	input wire logic [dltc_pkg::STATUS_W-1:0]     status,
	input wire logic                              table_done,
	input wire logic [dltc_pkg::RATE_W-1:0]       top_enabled_khz,
	input wire logic [dltc_pkg::RATE_W-1:0]       bottom_enabled_khz,
	input wire logic [dltc_pkg::LVL_W-1:0]        levels_seen
);
	import dltc_pkg::*;

	// Rates are reported only on a table that closes cleanly.
	a_rates_only_when_ok : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (!table_done || (status != ST_OK)) |->
			(top_enabled_khz == '0) && (bottom_enabled_khz == '0))
		else $error("rates reported outside a clean table close");

	// An empty table is only known at its close.
	a_empty_at_close : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !table_done |-> (status != ST_EMPTY))
		else $error("empty status before the table closed");

	// The highest enabled rate is never below the lowest one.
	a_rate_order : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && table_done && (status == ST_OK) |->
			(top_enabled_khz >= bottom_enabled_khz) && (levels_seen != '0))
		else $error("enabled rates out of order on a clean table");

	// The level count saturates at the table limit.
	a_count_limit : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (levels_seen <= LVL_W'(LEVEL_LIMIT_DEF)))
		else $error("level count beyond the table limit");

	// A stalled result transfer holds its payload.
	a_stall_hold : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) &&
			$stable(table_done) && $stable(levels_seen))
		else $error("stalled result changed");

endmodule

bind dvfs_level_table_checker dltc_checker u_dltc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.result_valid      (result_valid),
	.result_stall      (result_stall),
	.status            (status),
	.table_done        (table_done),
	.top_enabled_khz   (top_enabled_khz),
	.bottom_enabled_khz(bottom_enabled_khz),
	.levels_seen       (levels_seen)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dltc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 200;
	localparam int PHASE_LEVELS = 155;

	// One level of an operating-point table as it goes over the level channel.
	typedef struct packed {
		logic [RATE_W-1:0]                rate;
		logic [VOLT_W-1:0]                volt;
		logic                             en;
		logic [RATE_W-1:0]                clk0;
		logic [DIV_PORTS-1:0][DIV_W-1:0]  div;
		logic                             last;
	} level_t;

	logic clk;
	logic arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic                item_valid = 1'b0;
	logic                item_stall;
	logic [RATE_W-1:0]   level_rate = '0;
	logic [VOLT_W-1:0]   level_volt = '0;
	logic                level_enabled = 1'b0;
	logic [RATE_W-1:0]   first_clock = '0;
	logic [DIV_W-1:0]    divider_1 = '0;
	logic [DIV_W-1:0]    divider_2 = '0;
	logic [DIV_W-1:0]    divider_3 = '0;
	logic [DIV_W-1:0]    divider_4 = '0;
	logic [DIV_W-1:0]    divider_5 = '0;
	logic [DIV_W-1:0]    divider_6 = '0;
	logic [DIV_W-1:0]    divider_7 = '0;
	logic                is_last = 1'b0;

	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic                table_done;
	logic [RATE_W-1:0]   top_enabled_khz;
	logic [RATE_W-1:0]   bottom_enabled_khz;
	logic [LVL_W-1:0]    levels_seen;

	// Mirror of the configuration registers.
	logic [RATE_W-1:0]        band_lo = MIN_RATE_RST;
	logic [RATE_W-1:0]        band_hi = MAX_RATE_RST;
	logic [VOLT_W-1:0]        lim_max_volt = MAX_VOLT_RST;
	logic [CCOUNT_W-1:0]      clocks_in_use = CCOUNT_RST;
	logic signed [LVL_W-1:0]  boot_sel = LEVEL_SEL_RST;
	logic signed [LVL_W-1:0]  resume_sel = LEVEL_SEL_RST;

	// Predicted table state.
	logic [RATE_W-1:0]   last_rate = RATE_ALL_ONES;
	logic [VOLT_W-1:0]   last_volt = VOLT_ALL_ONES;
	logic [RATE_W-1:0]   fastest_en_rate = '0;
	logic [RATE_W-1:0]   slowest_en_rate = '0;
	logic [LVL_W-1:0]    en_count = '0;
	logic [LVL_W-1:0]    level_pos = '0;
	logic [STATUS_W-1:0] held_status = ST_OK;
	logic                boot_en_seen = 1'b0;
	logic                resume_en_seen = 1'b0;

	level_t       pending_levels[$];
	dltc_result_t expected_results[$];
	level_t       level_on_bus;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_armed = 1'b0;
	int hold_count = 0;
	int cycle_count = 0;
	int failures = 0;
	int levels_sent = 0;
	int results_seen = 0;
	int closes_by_status[4] = '{0, 0, 0, 0};

	dvfs_level_table_checker dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.level_rate         (level_rate),
		.level_volt         (level_volt),
		.level_enabled      (level_enabled),
		.first_clock        (first_clock),
		.divider_1          (divider_1),
		.divider_2          (divider_2),
		.divider_3          (divider_3),
		.divider_4          (divider_4),
		.divider_5          (divider_5),
		.divider_6          (divider_6),
		.divider_7          (divider_7),
		.is_last            (is_last),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.status             (status),
		.table_done         (table_done),
		.top_enabled_khz    (top_enabled_khz),
		.bottom_enabled_khz (bottom_enabled_khz),
		.levels_seen        (levels_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A boot or resume index fails when out of range or when it names a disabled level.
	function automatic bit index_invalid(input int idx, input int count, input bit en_seen);
		return (idx < -1 || idx >= count) || (idx >= 0 && !en_seen);
	endfunction

	// Checks one level against the table so far and returns the result it causes.
	function automatic dltc_result_t check_level(input level_t lv);
		dltc_result_t res;
		logic [STATUS_W-1:0] err;
		logic [STATUS_W-1:0] closing;
		int n;
		int boot_i;
		int resume_i;
		err = ST_OK;
		boot_i = int'(boot_sel);
		resume_i = int'(resume_sel);
		if (level_pos >= LVL_W'(LEVEL_LIMIT_DEF)) begin
			err = ST_ORDER;
		end else begin
			// Order, band and first-clock tests come first.
			if ((level_pos != '0 && lv.rate >= last_rate) || lv.rate < band_lo ||
			    lv.rate > band_hi || lv.clk0 != lv.rate)
				err = ST_ORDER;
			if (err == ST_OK) begin
				n = (clocks_in_use > CCOUNT_W'(MAX_CLOCKS_DEF)) ? int'(MAX_CLOCKS_DEF) :
					int'(clocks_in_use);
				for (int j = 1; j < n; j++)
					if (lv.div[j-1] > DIVIDER_MAX)
						err = ST_RANGE;
			end
			if (err == ST_OK && lv.en && (lv.volt < VOLTAGE_FLOOR ||
			    lv.volt > lim_max_volt || lv.volt > last_volt))
				err = ST_RANGE;
			// Only a clean level in a clean table moves the running state.
			if (err == ST_OK && held_status == ST_OK) begin
				last_rate = lv.rate;
				if (lv.en) begin
					last_volt = lv.volt;
					if (en_count == '0)
						fastest_en_rate = lv.rate;
					slowest_en_rate = lv.rate;
					en_count++;
					if (boot_i >= 0 && boot_i == int'(level_pos))
						boot_en_seen = 1'b1;
					if (resume_i >= 0 && resume_i == int'(level_pos))
						resume_en_seen = 1'b1;
				end
			end
			level_pos++;
		end
		if (held_status == ST_OK)
			held_status = err;

		res.status = held_status;
		res.table_done = lv.last;
		res.top_khz = '0;
		res.bottom_khz = '0;
		res.levels_seen = level_pos;

		// The closing level reports the table verdict and clears the table state.
		if (lv.last) begin
			closing = held_status;
			if (closing == ST_OK && en_count == '0)
				closing = ST_EMPTY;
			if (closing == ST_OK &&
			    (index_invalid(boot_i, int'(level_pos), boot_en_seen) ||
			     index_invalid(resume_i, int'(level_pos), resume_en_seen)))
				closing = ST_ORDER;
			res.status = closing;
			if (closing == ST_OK) begin
				res.top_khz = fastest_en_rate;
				res.bottom_khz = slowest_en_rate;
			end
			last_rate = RATE_ALL_ONES;
			last_volt = VOLT_ALL_ONES;
			fastest_en_rate = '0;
			slowest_en_rate = '0;
			en_count = '0;
			level_pos = '0;
			held_status = ST_OK;
			boot_en_seen = 1'b0;
			resume_en_seen = 1'b0;
		end
		return res;
	endfunction

	// Level driver: offers queued levels and predicts each one at its transfer.
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				expected_results.push_back(check_level(level_on_bus));
				levels_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_levels.size() != 0 &&
				    int'($urandom_range(0, 99)) >= send_idle_pct) begin
					level_on_bus = pending_levels.pop_front();
					item_valid    <= 1'b1;
					level_rate    <= level_on_bus.rate;
					level_volt    <= level_on_bus.volt;
					level_enabled <= level_on_bus.en;
					first_clock   <= level_on_bus.clk0;
					divider_1     <= level_on_bus.div[0];
					divider_2     <= level_on_bus.div[1];
					divider_3     <= level_on_bus.div[2];
					divider_4     <= level_on_bus.div[3];
					divider_5     <= level_on_bus.div[4];
					divider_6     <= level_on_bus.div[5];
					divider_7     <= level_on_bus.div[6];
					is_last       <= level_on_bus.last;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off once armed.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_armed && hold_count < HOLD_CYCLES) begin
			result_stall <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			result_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
		end
	end

	// Result monitor: each transfer is checked against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		dltc_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d, levels_seen %0d", status, levels_seen);
				failures++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
				if (table_done !== want.table_done) begin
					$error("table_done: expected %0d, got %0d", want.table_done, table_done);
					failures++;
				end
				if (top_enabled_khz !== want.top_khz) begin
					$error("top_enabled_khz: expected %0d, got %0d", want.top_khz,
						top_enabled_khz);
					failures++;
				end
				if (bottom_enabled_khz !== want.bottom_khz) begin
					$error("bottom_enabled_khz: expected %0d, got %0d", want.bottom_khz,
						bottom_enabled_khz);
					failures++;
				end
				if (levels_seen !== want.levels_seen) begin
					$error("levels_seen: expected %0d, got %0d", want.levels_seen, levels_seen);
					failures++;
				end
				if (want.table_done)
					closes_by_status[want.status]++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Register write over the configuration port, mirrored once it completes.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MIN_RATE:   band_lo = val[RATE_W-1:0];
			REG_MAX_RATE:   band_hi = val[RATE_W-1:0];
			REG_MAX_VOLT:   lim_max_volt = val[VOLT_W-1:0];
			REG_CCOUNT:     clocks_in_use = val[CCOUNT_W-1:0];
			REG_BOOT_LVL:   boot_sel = val[LVL_W-1:0];
			REG_RESUME_LVL: resume_sel = val[LVL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [31:0] min_r, input logic [31:0] max_r,
			input logic [31:0] max_v, input logic [31:0] clocks,
			input logic [31:0] boot_i, input logic [31:0] resume_i);
		write_reg(REG_MIN_RATE, min_r);
		write_reg(REG_MAX_RATE, max_r);
		write_reg(REG_MAX_VOLT, max_v);
		write_reg(REG_CCOUNT, clocks);
		write_reg(REG_BOOT_LVL, boot_i);
		write_reg(REG_RESUME_LVL, resume_i);
	endtask

	// Waits until every queued level is through and every result has come back.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_levels.size() != 0 || item_valid || expected_results.size() != 0);
	endtask

	task automatic add_level(input logic [RATE_W-1:0] rate, input logic [VOLT_W-1:0] volt,
			input logic en, input logic [RATE_W-1:0] clk0,
			input logic [DIV_PORTS-1:0][DIV_W-1:0] div, input logic last);
		level_t lv;
		lv.rate = rate;
		lv.volt = volt;
		lv.en = en;
		lv.clk0 = clk0;
		lv.div = div;
		lv.last = last;
		pending_levels.push_back(lv);
	endtask

	// Builds a well-formed table for the current registers, sometimes with one bad level.
	task automatic queue_table(input int n);
		level_t tbl [0:39];
		longint span;
		longint rstep;
		longint r;
		int v;
		int k;
		logic keep_last;
		span = longint'(band_hi) - longint'(band_lo);
		if (span < 0)
			span = 0;
		rstep = span / (n + 1);
		if (rstep < 1)
			rstep = 1;
		r = longint'(band_hi) - longint'($urandom_range(0, int'(rstep)));
		v = (lim_max_volt >= VOLTAGE_FLOOR) ?
			int'($urandom_range(VOLTAGE_FLOOR, lim_max_volt)) : int'(VOLTAGE_FLOOR);
		for (k = 0; k < n; k++) begin
			if (k > 0)
				r = r - longint'($urandom_range(1, int'(rstep)));
			if (r < 0)
				r = 0;
			tbl[k].rate = r[RATE_W-1:0];
			tbl[k].clk0 = r[RATE_W-1:0];
			tbl[k].en = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) != 0);
			if (tbl[k].en) begin
				if (v >= int'(VOLTAGE_FLOOR))
					v = int'($urandom_range(VOLTAGE_FLOOR, v));
				tbl[k].volt = VOLT_W'(v);
			end else begin
				tbl[k].volt = VOLT_W'($urandom);
			end
			for (int j = 0; j < DIV_PORTS; j++)
				tbl[k].div[j] = (j + 1 < int'(clocks_in_use)) ?
					DIV_W'($urandom_range(0, DIVIDER_MAX)) : DIV_W'($urandom);
			tbl[k].last = (k == n - 1);
		end

		// Occasionally break one level.
		if ($urandom_range(0, 4) == 0) begin
			k = int'($urandom_range(0, n - 1));
			case ($urandom_range(0, 4))
				0: begin
					tbl[k].rate = RATE_W'($urandom);
					tbl[k].clk0 = tbl[k].rate;
				end
				1: tbl[k].clk0 = tbl[k].rate ^ (RATE_W'(1) << $urandom_range(0, RATE_W - 1));
				2: tbl[k].div[$urandom_range(0, DIV_PORTS - 1)] = DIV_W'($urandom);
				3: begin
					tbl[k].en = 1'b1;
					tbl[k].volt = VOLT_W'($urandom);
				end
				default: begin
					keep_last = tbl[k].last;
					tbl[k].rate = RATE_W'($urandom);
					tbl[k].volt = VOLT_W'($urandom);
					tbl[k].en = 1'($urandom);
					tbl[k].clk0 = RATE_W'($urandom);
					for (int j = 0; j < DIV_PORTS; j++)
						tbl[k].div[j] = DIV_W'($urandom);
					tbl[k].last = keep_last;
				end
			endcase
		end
		for (k = 0; k < n; k++)
			pending_levels.push_back(tbl[k]);
	endtask

	// Register settings of the random phases, extremes among them.
	task automatic apply_phase_regs(input int ph);
		logic [31:0] lo;
		logic [31:0] sel_a;
		logic [31:0] sel_b;
		case (ph % 5)
			0: write_all_regs(32'd0, 32'(RATE_ALL_ONES), 32'(VOLT_ALL_ONES),
				32'(MAX_CLOCKS_DEF), '1, '1);
			1: begin
				lo = $urandom_range(0, RATE_ALL_ONES);
				write_all_regs(lo, lo, 32'(VOLTAGE_FLOOR), 32'd0, 32'd0, 32'd0);
			end
			2: begin
				lo = $urandom_range(0, 1 << 20);
				write_all_regs(lo, lo + $urandom_range(1000, 1 << 23),
					$urandom_range(VOLTAGE_FLOOR, VOLT_ALL_ONES), 32'd15,
					$urandom_range(0, 63), '1);
			end
			3: write_all_regs($urandom_range(0, 1000), 32'(RATE_ALL_ONES), 32'd0,
				$urandom_range(1, MAX_CLOCKS_DEF), 32'd31, 32'd2);
			default: begin
				sel_a = $urandom_range(0, 4);
				sel_b = $urandom_range(0, 4);
				write_all_regs($urandom_range(0, 5000),
					$urandom_range(10000000, RATE_ALL_ONES),
					$urandom_range(VOLTAGE_FLOOR, MAX_VOLT_RST), $urandom_range(0, 15),
					(sel_a == 0) ? '1 : sel_a - 32'd1, (sel_b == 0) ? '1 : sel_b - 32'd1);
			end
		endcase
	endtask

	initial begin
		int ph;
		int phase_levels;
		int n;
		int pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed tables under the reset register values.
		@(negedge clk);
		send_idle_pct = 25;
		recv_idle_pct = 85;
		add_level(RATE_ALL_ONES, MAX_VOLT_RST, 1'b1, RATE_ALL_ONES, '1, 1'b1);
		add_level(24'd0, 22'd0, 1'b0, 24'd0, '0, 1'b1);
		add_level(24'd5000, 22'd900000, 1'b1, 24'd5000, '0, 1'b0);
		add_level(24'd5000, 22'd800000, 1'b1, 24'd5000, '0, 1'b1);
		add_level(24'd7, 22'd600000, 1'b1, 24'd8, '0, 1'b1);
		add_level(24'd9000, 22'd499999, 1'b1, 24'd9000, '0, 1'b0);
		add_level(24'd9000, 22'd400000, 1'b1, 24'd8999, '0, 1'b1);
		add_level(24'd9000, 22'd500000, 1'b1, 24'd9000, '0, 1'b0);
		add_level(24'd8000, 22'd500001, 1'b1, 24'd8000, '0, 1'b1);
		add_level(24'd3000, MAX_VOLT_RST + 22'd1, 1'b1, 24'd3000, '0, 1'b1);
		wait_drained();

		// Directed tables with a narrow band, all dividers in use and boot/resume set.
		write_all_regs(32'd100, 32'd1000000, 32'(VOLT_ALL_ONES), 32'(MAX_CLOCKS_DEF),
			32'd1, 32'd0);
		@(negedge clk);
		add_level(24'd1000000, VOLT_ALL_ONES, 1'b1, 24'd1000000, {DIV_PORTS{DIVIDER_MAX}},
			1'b0);
		add_level(24'd100, VOLTAGE_FLOOR, 1'b1, 24'd100, '0, 1'b1);
		add_level(24'd1000001, 22'd600000, 1'b1, 24'd1000001, '0, 1'b1);
		add_level(24'd99, 22'd600000, 1'b1, 24'd99, '0, 1'b1);
		add_level(24'd2000, 22'd700000, 1'b1, 24'd2000, {16'd64, {(DIV_PORTS - 1){16'd0}}},
			1'b0);
		add_level(24'd1000, 22'd600000, 1'b1, 24'd1000, '0, 1'b1);
		add_level(24'd2000, 22'd700000, 1'b1, 24'd2000, '0, 1'b0);
		add_level(24'd1000, 22'd0, 1'b0, 24'd1000, '0, 1'b1);
		add_level(24'd2000, 22'd700000, 1'b1, 24'd2000, '0, 1'b1);
		wait_drained();

		// Random tables over several register settings and three flow-control modes.
		for (ph = 0; ph < 9; ph++) begin
			apply_phase_regs(ph);
			@(negedge clk);
			send_idle_pct = (ph < 3) ? 25 : (ph < 6) ? 85 : 0;
			recv_idle_pct = (ph < 3) ? 85 : (ph < 6) ? 25 : 0;
			phase_levels = 0;
			while (phase_levels < PHASE_LEVELS) begin
				pick = int'($urandom_range(0, 99));
				n = (pick < 4) ? int'($urandom_range(33, 36)) :
					(pick < 14) ? int'($urandom_range(7, 32)) : int'($urandom_range(1, 6));
				queue_table(n);
				phase_levels += n;
			end
			if (ph == 0)
				hold_armed = 1'b1;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d levels and %0d results over nine register settings, a long",
			levels_sent, results_seen);
		$display("output hold-off and three flow-control modes; closings %0d/%0d/%0d/%0d",
			closes_by_status[ST_OK], closes_by_status[ST_ORDER],
			closes_by_status[ST_RANGE], closes_by_status[ST_EMPTY]);
		$display("counted as ok/order/range/empty.");
		if (failures == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
